// File: sv/mbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, fixed-point constants and helpers for the escape-time core.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAC_BITS      = 28;
    localparam int Q_W            = 32;               // Q4.28 word
    localparam int PROD_W         = 2 * Q_W;          // exact product
    localparam int SQ_W           = PROD_W - FRAC_BITS; // product after shift
    localparam int SAT_W          = PROD_W + 1;       // widest value to saturate
    localparam int ITER_W         = 10;
    localparam int PIX_W          = 11;
    localparam int COLOR_W        = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int ITER_LIMIT_MAX = 1023;

    localparam logic signed [Q_W-1:0] Q_HI  = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_LO  = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_TWO = Q_W'(64'sd1 <<< (FRAC_BITS + 1));
    localparam logic [SQ_W:0]         Q_FOUR = (SQ_W+1)'(64'd1 << (FRAC_BITS + 2));

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RE_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RE_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IM_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IM_STEP   = 3'd4;

    localparam logic [ITER_W-1:0] LIMIT_RST     = 10'd100;
    localparam logic [Q_W-1:0]    RE_ORIGIN_RST = 32'hD800_0000;
    localparam logic [Q_W-1:0]    RE_STEP_RST   = 32'd1468006;
    localparam logic [Q_W-1:0]    IM_ORIGIN_RST = 32'hF000_0000;
    localparam logic [Q_W-1:0]    IM_STEP_RST   = 32'd1118481;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_CADD,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ITER_W-1:0]    limit;
        logic signed [Q_W-1:0] re_origin;
        logic signed [Q_W-1:0] re_step;
        logic signed [Q_W-1:0] im_origin;
        logic signed [Q_W-1:0] im_step;
    } t_cfg;

    typedef struct packed {
        logic signed [Q_W-1:0] a0;
        logic signed [Q_W-1:0] b0;
        logic signed [Q_W-1:0] a1;
        logic signed [Q_W-1:0] b1;
        logic signed [Q_W-1:0] a2;
        logic signed [Q_W-1:0] b2;
    } t_mul_ops;

    typedef struct packed {
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
    } t_mul_prod;

    typedef struct packed {
        logic [ITER_W-1:0] count;
        logic              reached;
    } t_res;

    // clamp to the Q4.28 range
    function automatic logic signed [Q_W-1:0] f_sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = {{(SAT_W-Q_W){Q_HI[Q_W-1]}}, Q_HI};
        lo = {{(SAT_W-Q_W){Q_LO[Q_W-1]}}, Q_LO};
        if (v > hi) begin
            return Q_HI;
        end else if (v < lo) begin
            return Q_LO;
        end
        return v[Q_W-1:0];
    endfunction

    // eleven-band palette, packed red, blue, green, alpha
    function automatic logic [COLOR_W-1:0] f_palette(input logic [ITER_W-1:0] t);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'd0;
        g = 8'd0;
        b = 8'd0;
        priority if (t <= 10'd1) begin
            r = 8'd255;
        end else if (t == 10'd2) begin
            r = 8'd255; g = 8'd127;
        end else if (t == 10'd3) begin
            r = 8'd255; g = 8'd255;
        end else if (t == 10'd4) begin
            r = 8'd127; g = 8'd255;
        end else if (t == 10'd5) begin
            g = 8'd255;
        end else if (t == 10'd6) begin
            g = 8'd255; b = 8'd127;
        end else if (t == 10'd7) begin
            g = 8'd255; b = 8'd255;
        end else if (t == 10'd8) begin
            b = 8'd255;
        end else if (t == 10'd9) begin
            r = 8'd127; b = 8'd255;
        end else if (t < 10'd100) begin
            r = 8'd255; b = 8'd255;
        end else begin
            r = 8'd0;
        end
        return {r, b, g, 8'd0};
    endfunction

endpackage

// File: sv/mbe_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_mul
// Three-lane signed 32x32 multiplier with registered exact products.
// ----------------------------------------------------------------------------
module mbe_mul (
    input  logic               i_clk,
    input  mbe_pkg::t_mul_ops  i_ops,
    output mbe_pkg::t_mul_prod o_prod
);
    import mbe_pkg::*;

    t_mul_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod.p0 <= i_ops.a0 * i_ops.b0;
        r_prod.p1 <= i_ops.a1 * i_ops.b1;
        r_prod.p2 <= i_ops.a2 * i_ops.b2;
    end

    assign o_prod = r_prod;

endmodule

// File: sv/mbe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_seq
// Sequencer and z datapath: maps the pixel to c, then alternates a multiply
// pass and an update/escape step on the shared multiplier.
// ----------------------------------------------------------------------------
module mbe_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbe_pkg::t_cfg                  i_cfg,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  logic [mbe_pkg::PIX_W-1:0]      i_row,
    input  logic [mbe_pkg::PIX_W-1:0]      i_col,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output mbe_pkg::t_res                  o_res
);
    import mbe_pkg::*;

    t_state                r_state, n_state;
    logic [PIX_W-1:0]      r_row, n_row;
    logic [PIX_W-1:0]      r_col, n_col;
    logic [ITER_W-1:0]     r_limit, n_limit;
    logic [ITER_W-1:0]     r_iter, n_iter;
    logic signed [Q_W-1:0] r_cr, n_cr;
    logic signed [Q_W-1:0] r_ci, n_ci;
    logic signed [Q_W-1:0] r_zr, n_zr;
    logic signed [Q_W-1:0] r_zi, n_zi;
    t_res                  r_res, n_res;

    t_mul_ops  w_ops;
    t_mul_prod w_prod;

    logic signed [SQ_W-1:0] w_rr;
    logic signed [SQ_W-1:0] w_ii;
    logic signed [SQ_W-1:0] w_ri;
    logic signed [SQ_W:0]   w_diff;
    logic signed [SQ_W:0]   w_two_ri;
    logic signed [Q_W-1:0]  w_zr_s;
    logic signed [Q_W-1:0]  w_zi_s;
    logic signed [Q_W:0]    w_zr_sum;
    logic signed [Q_W:0]    w_zi_sum;
    logic [SQ_W:0]          w_mag;
    logic                   w_escape;
    logic signed [SAT_W-1:0] w_cr_sum;
    logic signed [SAT_W-1:0] w_ci_sum;

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_ops  (w_ops),
        .o_prod (w_prod)
    );

    // multiplier operands: pixel index times step while mapping, else z terms
    always_comb begin
        if (r_state == ST_MAP) begin
            w_ops.a0 = {{(Q_W-PIX_W){1'b0}}, r_col};
            w_ops.b0 = i_cfg.re_step;
            w_ops.a1 = {{(Q_W-PIX_W){1'b0}}, r_row};
            w_ops.b1 = i_cfg.im_step;
        end else begin
            w_ops.a0 = r_zr;
            w_ops.b0 = r_zr;
            w_ops.a1 = r_zi;
            w_ops.b1 = r_zi;
        end
        w_ops.a2 = r_zr;
        w_ops.b2 = r_zi;
    end

    // floor shift of the exact products
    assign w_rr = w_prod.p0[PROD_W-1:FRAC_BITS];
    assign w_ii = w_prod.p1[PROD_W-1:FRAC_BITS];
    assign w_ri = w_prod.p2[PROD_W-1:FRAC_BITS];

    assign w_diff   = {w_rr[SQ_W-1], w_rr} - {w_ii[SQ_W-1], w_ii};
    assign w_two_ri = {w_ri, 1'b0};
    assign w_zr_s   = f_sat_q({{(SAT_W-SQ_W-1){w_diff[SQ_W]}}, w_diff});
    assign w_zi_s   = f_sat_q({{(SAT_W-SQ_W-1){w_two_ri[SQ_W]}}, w_two_ri});
    assign w_zr_sum = {w_zr_s[Q_W-1], w_zr_s} + {r_cr[Q_W-1], r_cr};
    assign w_zi_sum = {w_zi_s[Q_W-1], w_zi_s} + {r_ci[Q_W-1], r_ci};

    // squares are of the z that the previous step produced
    assign w_mag    = {1'b0, w_rr} + {1'b0, w_ii};
    assign w_escape = (r_zr >= Q_TWO) || (r_zr <= -Q_TWO) ||
                      (r_zi >= Q_TWO) || (r_zi <= -Q_TWO) || (w_mag >= Q_FOUR);

    assign w_cr_sum = {{(SAT_W-Q_W){i_cfg.re_origin[Q_W-1]}}, i_cfg.re_origin}
                    + {w_prod.p0[PROD_W-1], w_prod.p0};
    assign w_ci_sum = {{(SAT_W-Q_W){i_cfg.im_origin[Q_W-1]}}, i_cfg.im_origin}
                    + {w_prod.p1[PROD_W-1], w_prod.p1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_row   <= n_row;
        r_col   <= n_col;
        r_limit <= n_limit;
        r_iter  <= n_iter;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_res   <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_limit     = r_limit;
        n_iter      = r_iter;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_res       = r_res;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_row   = i_row;
                    n_col   = i_col;
                    n_limit = (32'(i_cfg.limit) > ITER_LIMIT_MAX) ?
                              ITER_W'(ITER_LIMIT_MAX) : i_cfg.limit;
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_state = ST_CADD;
            end
            ST_CADD: begin
                n_cr   = f_sat_q(w_cr_sum);
                n_ci   = f_sat_q(w_ci_sum);
                n_zr   = '0;
                n_zi   = '0;
                n_iter = '0;
                if (r_limit == '0) begin
                    n_res.count   = '0;
                    n_res.reached = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                // z = 0 never escapes, so r_iter >= 1 on an escape
                if (w_escape) begin
                    n_res.count   = r_iter - 1'b1;
                    n_res.reached = 1'b0;
                    n_state       = ST_DONE;
                end else if (r_iter == r_limit) begin
                    n_res.count   = r_limit;
                    n_res.reached = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    n_zr    = f_sat_q({{(SAT_W-Q_W-1){w_zr_sum[Q_W]}}, w_zr_sum});
                    n_zi    = f_sat_q({{(SAT_W-Q_W-1){w_zi_sum[Q_W]}}, w_zi_sum});
                    n_iter  = r_iter + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// File: sv/mandelbrot_escape_time_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Escape-time evaluator: one pixel in, escape count, limit flag and palette
// color out. Q4.28 arithmetic on a shared three-lane multiplier.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload (low bit up)
//  --------+-----+-----------------------+---------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready | pixel_row[10:0], pixel_col[21:11]
//  m       | out | o_m_tvalid/i_m_tready | escape_count[9:0], reached_limit[10],
//          |     |                       | pixel_color[42:11]
//  cfg     | in  | i_cfg_valid/o_cfg_ready | index 0..4, 32-bit data
//
//  Each complex step is one multiply pass and one update step; a zero limit runs
//  none. A new request is taken only once the previous result has left the
//  sequencer.
//  Reset loads the default view and a limit of 100.
//  A result stalled at the output holds; the next pixel is still taken and its
//  result waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // pixel_row, pixel_col, pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // escape_count, reached_limit, pixel_color, pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import mbe_pkg::*;

    t_cfg               r_cfg;
    logic               r_m_valid;
    t_res               r_out;
    logic [COLOR_W-1:0] r_color;

    logic w_res_valid;
    logic w_res_ready;
    t_res w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit     <= LIMIT_RST;
            r_cfg.re_origin <= RE_ORIGIN_RST;
            r_cfg.re_step   <= RE_STEP_RST;
            r_cfg.im_origin <= IM_ORIGIN_RST;
            r_cfg.im_step   <= IM_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LIMIT:     r_cfg.limit     <= i_cfg_data[ITER_W-1:0];
                CFG_RE_ORIGIN: r_cfg.re_origin <= i_cfg_data;
                CFG_RE_STEP:   r_cfg.re_step   <= i_cfg_data;
                CFG_IM_ORIGIN: r_cfg.im_origin <= i_cfg_data;
                CFG_IM_STEP:   r_cfg.im_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mbe_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_row       (i_s_tdata[PIX_W-1:0]),
        .i_col       (i_s_tdata[2*PIX_W-1:PIX_W]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out   <= w_res;
            r_color <= f_palette(w_res.count);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'd0, r_color, r_out.reached, r_out.count};

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("pixel core ready right after taking a request");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[ITER_W] |-> o_m_tdata[ITER_W-1:0] == r_cfg.limit)
        else $error("limit flag set but count differs from the limit");

    a_escape_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[ITER_W] |-> o_m_tdata[ITER_W-1:0] < r_cfg.limit)
        else $error("escaped pixel reports count at or above the limit");

endmodule

// File: tb/mandelbrot_escape_time_pixel_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core_tb
// Self-checking bench for the escape-time pixel core. A directed table hits the
// reset view, zero and full limits, saturated c and the palette bands. Random
// views of the set follow, with noise views mixed in. Every result is compared field
// by field with a table value or a fixed-point escape-time predictor in this file.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core_tb;
    import mbe_pkg::*;

    localparam int     NUM_PHASES   = 14;
    localparam int     DRAIN_CYCLES = 2 * ITER_LIMIT_MAX + 4;
    localparam longint Q_MAX        = (64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1;
    localparam longint Q_MIN        = -Q_MAX - 64'sd1;
    localparam longint BAIL_PART    = 64'sd1 <<< (FRAC_BITS + 1);
    localparam longint BAIL_MAG2    = 64'sd1 <<< (FRAC_BITS + 2);

    // indexes past the last register; writes there must not land anywhere
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [COLOR_W-1:0] RGB_RED     = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] RGB_MAGENTA = 32'hFFFF_0000;
    localparam logic [COLOR_W-1:0] RGB_BLACK   = 32'h0000_0000;
    localparam logic [Q_W-1:0]     Q_SIXTEENTH = 32'h0100_0000;

    typedef struct packed {
        logic [ITER_W-1:0]  count;
        logic               reached;
        logic [COLOR_W-1:0] color;
    } t_pixel_out;

    typedef enum logic {V_PIX, V_CFG} t_vkind;

    typedef struct packed {
        t_vkind               kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        logic [PIX_W-1:0]     row;
        logic [PIX_W-1:0]     col;
        logic                 typed;
        t_pixel_out           want;
    } t_vector;

    localparam t_pixel_out W_NONE    = '0;
    localparam t_pixel_out W_ESC0    = '{10'd0,    1'b0, RGB_RED};
    localparam t_pixel_out W_NOLIMIT = '{10'd0,    1'b1, RGB_RED};
    localparam t_pixel_out W_HOLD1   = '{10'd1,    1'b1, RGB_RED};
    localparam t_pixel_out W_HOLD99  = '{10'd99,   1'b1, RGB_MAGENTA};
    localparam t_pixel_out W_HOLD100 = '{10'd100,  1'b1, RGB_BLACK};
    localparam t_pixel_out W_HOLD1K  = '{10'd1023, 1'b1, RGB_BLACK};

    localparam int NUM_DIRECTED = 45;
    localparam t_vector DIRECTED [NUM_DIRECTED] = '{
        // reset view: corner escapes at once, (240,457) sits next to c = 0
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd0,    1'b1, W_ESC0},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd2047, 11'd2047, 1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd240,  11'd457,  1'b1, W_HOLD100},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd240,  11'd300,  1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd240,  11'd200,  1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd480,  11'd100,  1'b0, W_NONE},
        '{V_CFG, CFG_SPARE_HI,  32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_SPARE_LO,  32'hFFFF_FFFF, 11'd0,   11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd240,  11'd457,  1'b1, W_HOLD100},
        // no iterations at all
        '{V_CFG, CFG_LIMIT,     32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd240,  11'd457,  1'b1, W_NOLIMIT},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd2047, 11'd0,    1'b1, W_NOLIMIT},
        // c = 0 never escapes
        '{V_CFG, CFG_LIMIT,     32'd1023,     11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_RE_ORIGIN, 32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_RE_STEP,   32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_IM_ORIGIN, 32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_IM_STEP,   32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd2047, 11'd2047, 1'b1, W_HOLD1K},
        '{V_CFG, CFG_LIMIT,     32'd1,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd5,    11'd9,    1'b1, W_HOLD1},
        '{V_CFG, CFG_LIMIT,     32'd99,       11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd0,    1'b1, W_HOLD99},
        // c saturates high and low on the real axis
        '{V_CFG, CFG_RE_ORIGIN, Q_HI,         11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_RE_STEP,   Q_HI,         11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd2047, 1'b1, W_ESC0},
        '{V_CFG, CFG_RE_ORIGIN, Q_LO,         11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_RE_STEP,   Q_LO,         11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd2047, 1'b1, W_ESC0},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd0,    1'b1, W_ESC0},
        // imaginary axis: row 1 lands one LSB below zero, row 2047 saturates
        '{V_CFG, CFG_RE_ORIGIN, 32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_RE_STEP,   32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_IM_ORIGIN, Q_LO,         11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_IM_STEP,   Q_HI,         11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd2047, 11'd0,    1'b1, W_ESC0},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd1,    11'd0,    1'b1, W_HOLD99},
        // real axis at col/16 walks the palette bands
        '{V_CFG, CFG_LIMIT,     32'd100,      11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_IM_ORIGIN, 32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_IM_STEP,   32'd0,        11'd0,    11'd0,    1'b0, W_NONE},
        '{V_CFG, CFG_RE_STEP,   Q_SIXTEENTH,  11'd0,    11'd0,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd5,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd6,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd7,    1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd10,   1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd16,   1'b0, W_NONE},
        '{V_PIX, CFG_LIMIT,     32'd0,        11'd0,    11'd32,   1'b0, W_NONE}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata   = '0;   // pixel_row, pixel_col, pad
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [47:0]          o_m_tdata;          // escape_count, reached_limit, pixel_color, pad
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;

    t_cfg        view_cfg;
    t_pixel_out  expected_pixels [$];
    int unsigned send_gap_pct   = 7;
    int unsigned take_stall_pct = 67;
    int          fault_cnt      = 0;
    int          pixels_sent    = 0;
    int          regs_written   = 0;
    int          results_seen   = 0;
    int          held_seen      = 0;

    mandelbrot_escape_time_pixel_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // exact product, floor to Q4.28
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic [COLOR_W-1:0] band_color(input logic [ITER_W-1:0] t);
        logic [7:0] red;
        logic [7:0] grn;
        logic [7:0] blu;
        red = 8'h00;
        grn = 8'h00;
        blu = 8'h00;
        case (t)
            10'd0, 10'd1: red = 8'hFF;
            10'd2: begin red = 8'hFF; grn = 8'h7F; end
            10'd3: begin red = 8'hFF; grn = 8'hFF; end
            10'd4: begin red = 8'h7F; grn = 8'hFF; end
            10'd5: grn = 8'hFF;
            10'd6: begin grn = 8'hFF; blu = 8'h7F; end
            10'd7: begin grn = 8'hFF; blu = 8'hFF; end
            10'd8: blu = 8'hFF;
            10'd9: begin red = 8'h7F; blu = 8'hFF; end
            default: begin
                if (t < 10'd100) begin
                    red = 8'hFF;
                    blu = 8'hFF;
                end
            end
        endcase
        return {red, blu, grn, 8'h00};
    endfunction

    function automatic t_pixel_out predict_pixel(input logic [PIX_W-1:0] row,
                                                 input logic [PIX_W-1:0] col);
        longint      c_re;
        longint      c_im;
        longint      z_re;
        longint      z_im;
        longint      re2;
        longint      im2;
        longint      re_im;
        int unsigned lim;
        int unsigned k;
        t_pixel_out  res;
        c_re = clamp_q(longint'($signed(view_cfg.re_origin))
                       + longint'(col) * longint'($signed(view_cfg.re_step)));
        c_im = clamp_q(longint'($signed(view_cfg.im_origin))
                       + longint'(row) * longint'($signed(view_cfg.im_step)));
        lim = view_cfg.limit;
        if (lim > ITER_LIMIT_MAX) lim = ITER_LIMIT_MAX;
        z_re = 0;
        z_im = 0;
        res.count   = ITER_W'(lim);
        res.reached = 1'b1;
        for (k = 0; k < lim; k++) begin
            re2   = fx_mul(z_re, z_re);
            im2   = fx_mul(z_im, z_im);
            re_im = fx_mul(z_re, z_im);
            z_re  = clamp_q(clamp_q(re2 - im2) + c_re);
            z_im  = clamp_q(clamp_q(re_im * 2) + c_im);
            if (z_re >= BAIL_PART || z_re <= -BAIL_PART || z_im >= BAIL_PART ||
                z_im <= -BAIL_PART || fx_mul(z_re, z_re) + fx_mul(z_im, z_im) >= BAIL_MAG2) begin
                res.count   = ITER_W'(k);
                res.reached = 1'b0;
                break;
            end
        end
        res.color = band_color(res.count);
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col,
                              input logic typed, input t_pixel_out want);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {2'b00, col, row};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (typed) begin
            expected_pixels.push_back(want);
        end else begin
            expected_pixels.push_back(predict_pixel(row, col));
        end
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LIMIT:     view_cfg.limit     = value[ITER_W-1:0];
            CFG_RE_ORIGIN: view_cfg.re_origin = value;
            CFG_RE_STEP:   view_cfg.re_step   = value;
            CFG_IM_ORIGIN: view_cfg.im_origin = value;
            CFG_IM_STEP:   view_cfg.im_step   = value;
            default: ;
        endcase
        regs_written++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic settle;
        i_s_tvalid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= take_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pixel_out got;
        t_pixel_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.count   = o_m_tdata[ITER_W-1:0];
            got.reached = o_m_tdata[ITER_W];
            got.color   = o_m_tdata[ITER_W+COLOR_W:ITER_W+1];
            results_seen++;
            if (got.reached) held_seen++;
            if (expected_pixels.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("%0t: result with nothing pending: count %0d flag %0b color %h",
                             $realtime, got.count, got.reached, got.color);
            end else begin
                want = expected_pixels.pop_front();
                if (got.count !== want.count || got.reached !== want.reached ||
                    got.color !== want.color) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("%0t: pixel mismatch: count %0d/%0d flag %0b/%0b color %h/%h",
                                 $realtime, got.count, want.count, got.reached, want.reached,
                                 got.color, want.color);
                end
            end
        end
    end

    initial begin
        #(500_000_000);
        $display("mandelbrot_escape_time_pixel_core_tb: done, errors");
        $finish;
    end

    initial begin
        int               ph;
        int               n;
        int               num_items;
        logic [31:0]      lim_word;
        longint           step_re;
        longint           step_im;
        longint           mid_re;
        longint           mid_im;
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
        t_vector          v;

        view_cfg.limit     = LIMIT_RST;
        view_cfg.re_origin = RE_ORIGIN_RST;
        view_cfg.re_step   = RE_STEP_RST;
        view_cfg.im_origin = IM_ORIGIN_RST;
        view_cfg.im_step   = IM_STEP_RST;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (n = 0; n < NUM_DIRECTED; n++) begin
            v = DIRECTED[n];
            if (v.kind == V_CFG) begin
                settle();
                write_reg(v.idx, v.data);
            end else begin
                push_pixel(v.row, v.col, v.typed, v.want);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph * 3 / NUM_PHASES)
                0: begin send_gap_pct = 7;  take_stall_pct = 67; end
                1: begin send_gap_pct = 67; take_stall_pct = 7;  end
                default: begin send_gap_pct = 0; take_stall_pct = 0; end
            endcase
            settle();
            if (ph == 6 || ph == 12) begin
                // noise view: every register bit random, mostly saturated c
                num_items = 150;
                write_reg(CFG_LIMIT, $urandom);
                write_reg(CFG_RE_ORIGIN, $urandom);
                write_reg(CFG_RE_STEP, $urandom);
                write_reg(CFG_IM_ORIGIN, $urandom);
                write_reg(CFG_IM_STEP, $urandom);
            end else begin
                case (ph)
                    2:       begin lim_word = 32'd1023; num_items = 12; end
                    5:       begin lim_word = 32'd0;    num_items = 30; end
                    9:       begin lim_word = 32'd1;    num_items = 60; end
                    default: begin lim_word = $urandom_range(2, 127); num_items = 170; end
                endcase
                // window placed over the set, random zoom and orientation
                step_re = longint'($urandom_range(2000, 900000));
                if ($urandom_range(0, 7) == 0) step_re = -step_re;
                step_im = longint'($urandom_range(2000, 600000));
                if ($urandom_range(0, 7) == 0) step_im = -step_im;
                mid_re = longint'($urandom_range(0, 536870912)) - 469762048;
                mid_im = longint'($urandom_range(0, 536870912)) - 268435456;
                write_reg(CFG_LIMIT, lim_word);
                write_reg(CFG_RE_ORIGIN, 32'(mid_re - 1024 * step_re));
                write_reg(CFG_RE_STEP, 32'(step_re));
                write_reg(CFG_IM_ORIGIN, 32'(mid_im - 1024 * step_im));
                write_reg(CFG_IM_STEP, 32'(step_im));
            end
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);

            for (n = 0; n < num_items; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    row = $urandom_range(0, 1) ? '1 : '0;
                    col = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    row = PIX_W'($urandom_range(0, 2047));
                    col = PIX_W'($urandom_range(0, 2047));
                end
                push_pixel(row, col, 1'b0, W_NONE);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d pixels over %0d register writes and %0d views", pixels_sent,
                 regs_written, NUM_PHASES);
        $display("%0d results checked, %0d held to the limit, %0d faults", results_seen,
                 held_seen, fault_cnt);
        if (fault_cnt == 0) begin
            $display("mandelbrot_escape_time_pixel_core_tb: done, clean");
        end else begin
            $display("mandelbrot_escape_time_pixel_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/mbe_pkg.sv
sv/mbe_mul.sv
sv/mbe_seq.sv
sv/mandelbrot_escape_time_pixel_core.sv
tb/mandelbrot_escape_time_pixel_core_tb.sv
